/* rtl/bpt_pkg.sv */
// Shared types and constants for the battery percent tracker.
// Used by bpt_div, battery_percent_tracker and the testbench; depends on nothing else.
package bpt_pkg;

    // Field widths fixed by the interface.
    localparam int VW = 10;   // cell voltage and knot registers
    localparam int DW = 6;    // drop compensation
    localparam int PW = 7;    // percent
    localparam int GW = 3;    // bar grade
    localparam int CDW = 7;   // countdown
    localparam int CIW = 3;   // configuration register index

    // Configuration register indexes.
    localparam logic [CIW-1:0] CFG_VOLT_FLOOR = 3'd0;
    localparam logic [CIW-1:0] CFG_KNOT_20    = 3'd1;
    localparam logic [CIW-1:0] CFG_KNOT_40    = 3'd2;
    localparam logic [CIW-1:0] CFG_KNOT_60    = 3'd3;
    localparam logic [CIW-1:0] CFG_KNOT_80    = 3'd4;
    localparam logic [CIW-1:0] CFG_KNOT_TOP   = 3'd5;
    localparam logic [CIW-1:0] CFG_DROP_COMP  = 3'd6;

    // Configuration values after reset.
    localparam logic [VW-1:0] RST_VOLT_FLOOR = 10'd330;
    localparam logic [VW-1:0] RST_KNOT_20    = 10'd365;
    localparam logic [VW-1:0] RST_KNOT_40    = 10'd371;
    localparam logic [VW-1:0] RST_KNOT_60    = 10'd383;
    localparam logic [VW-1:0] RST_KNOT_80    = 10'd397;
    localparam logic [VW-1:0] RST_KNOT_TOP   = 10'd415;
    localparam logic [DW-1:0] RST_DROP_COMP  = 6'd0;

    // Percent levels.
    localparam logic [PW-1:0] PCT_FULL      = 7'd100;
    localparam logic [PW-1:0] PCT_CHG_TOP   = 7'd99;
    localparam logic [PW-1:0] PCT_JUMP_BELOW = 7'd80;

    // Full-charge ramp: one step every RAMP_TICKS + 1 ticks.
    localparam logic [5:0] RAMP_TICKS     = 6'd40;
    localparam logic [5:0] RST_RAMP_COUNT = 6'd20;

    // Slew counter levels.
    localparam logic signed [15:0] SLEW_MID    = 16'sd100;
    localparam logic signed [15:0] SLEW_STEP   = 16'sd200;
    localparam logic signed [16:0] SLEW_MAX    = 17'sd32767;

    // Gap thresholds of the slew counter and the resync limit.
    localparam logic [7:0] GAP_CLEAR   = 8'd15;
    localparam logic [7:0] GAP_BIG     = 8'd10;
    localparam logic [7:0] GAP_MID     = 8'd5;
    localparam logic [7:0] GAP_SMALL   = 8'd3;
    localparam logic [7:0] GAP_RESYNC  = 8'd30;

    // Lower bounds of bar grades two to five.
    localparam logic [PW-1:0] GRADE_2_MIN = 7'd21;
    localparam logic [PW-1:0] GRADE_3_MIN = 7'd41;
    localparam logic [PW-1:0] GRADE_4_MIN = 7'd61;
    localparam logic [PW-1:0] GRADE_5_MIN = 7'd81;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEARCH,
        ST_DIVIDE,
        ST_TRACK,
        ST_SETTLE,
        ST_FULL,
        ST_DONE
    } state_t;

    // Sequencer strobes.
    typedef struct packed {
        logic in_ready;
        logic div_start;
        logic out_load;
    } ctl_t;

    // Bar grade of a displayed percent.
    function automatic logic [GW-1:0] grade_of(input logic [PW-1:0] p);
        logic [GW-1:0] g;
        begin
            priority if (p >= GRADE_5_MIN) g = 3'd5;
            else if (p >= GRADE_4_MIN) g = 3'd4;
            else if (p >= GRADE_3_MIN) g = 3'd3;
            else if (p >= GRADE_2_MIN) g = 3'd2;
            else if (p != '0) g = 3'd1;
            else g = 3'd0;
            return g;
        end
    endfunction

endpackage

/* rtl/battery_percent_tracker.sv */
// Battery percent tracker: one input beat per tick gives one result beat with
// the displayed percent, its bar grade and the countdown. The time from
// acceptance to result is set by the knot search, which compares one knot per
// cycle, and by the serial divider, which makes one quotient bit per cycle; the
// full-charge path skips both. One item is in work at a time; the next is taken
// once the previous result sits in the output register, which may still wait
// for the consumer. Configuration writes are taken in any cycle and should
// only be issued while the block is idle. Depends on bpt_pkg and bpt_div.
module battery_percent_tracker #(
    parameter int KNOTS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpt_pkg::VW-1:0]        cell_volt,
    input  logic                          charging,
    input  logic                          full_flag,
    input  logic                          load_event,
    input  logic                          force_resync,
    input  logic [bpt_pkg::CDW-1:0]       countdown_in,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpt_pkg::PW-1:0]        percent,
    output logic [bpt_pkg::GW-1:0]        bar_grade,
    output logic [bpt_pkg::CDW-1:0]       countdown_out,
    // Configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bpt_pkg::CIW-1:0]       cfg_index,
    input  logic [bpt_pkg::VW-1:0]        cfg_data
);

    localparam int SEG_PCT = 100 / (KNOTS - 1);
    localparam int QW      = $clog2(SEG_PCT + 1);
    localparam int NW      = $clog2(1024 * SEG_PCT);
    localparam int IW      = $clog2(KNOTS);
    localparam int VW      = bpt_pkg::VW;
    localparam int PW      = bpt_pkg::PW;
    localparam int CDW     = bpt_pkg::CDW;

    // Sequencer
    bpt_pkg::state_t state_reg;
    bpt_pkg::state_t state_next;
    bpt_pkg::ctl_t   ctl;

    // Configuration registers
    logic [VW-1:0]          volt_floor_reg;
    logic [VW-1:0]          knot_20_reg;
    logic [VW-1:0]          knot_40_reg;
    logic [VW-1:0]          knot_60_reg;
    logic [VW-1:0]          knot_80_reg;
    logic [VW-1:0]          knot_top_reg;
    logic [bpt_pkg::DW-1:0] drop_comp_reg;

    // Tracker state
    logic [PW-1:0]        shown_reg;
    logic signed [15:0]   slew_reg;
    logic [5:0]           ramp_reg;
    logic [7:0]           prev_reg;
    logic                 synced_reg;
    logic                 load_latch_reg;

    // Per-item working registers
    logic [VW-1:0]  volt_reg;
    logic           chg_reg;
    logic           full_reg;
    logic           force_reg;
    logic [CDW-1:0] cd_reg;
    logic [PW-1:0]  a_reg;
    logic [PW-1:0]  p_reg;
    logic [IW-1:0]  idx_reg;
    logic [PW-1:0]  base_reg;
    logic [VW-1:0]  lo_reg;

    // Output register
    logic                   out_valid_reg;
    logic [PW-1:0]          percent_reg;
    logic [bpt_pkg::GW-1:0] grade_reg;
    logic [CDW-1:0]         cd_out_reg;

    // Combinational values
    logic [VW-1:0]  volt_comp;
    logic [7:0]     idx_wide;
    logic [VW-1:0]  knot_sel;
    logic           search_more;
    logic [VW-1:0]  den_sel;
    logic [VW-1:0]  off_sel;
    logic [NW-1:0]  num_sel;
    logic           div_done;
    logic [QW-1:0]  div_quo;

    logic [PW-1:0]        p_snap;
    logic [7:0]           a8;
    logic [7:0]           p8;
    logic                 latch_live;
    logic                 latch_next;
    logic signed [16:0]   slew_base;
    logic signed [16:0]   slew_sum;
    logic signed [15:0]   slew_sat;

    logic signed [15:0]   slew_next;
    logic [PW-1:0]        p_fin;
    logic                 synced_next;

    logic [PW-1:0]        pf;
    logic [CDW-1:0]       cdf;
    logic [5:0]           ramp_next;

    // Drop compensation applied as the beat is taken.
    always_comb
    begin
        volt_comp = cell_volt;
        if (charging && (cell_volt > volt_floor_reg))
        begin
            volt_comp = (cell_volt > VW'(drop_comp_reg)) ?
                        (cell_volt - VW'(drop_comp_reg)) : '0;
        end
    end

    // Knot table read; entries past knot_80 read as the top knot.
    assign idx_wide = 8'(idx_reg);

    always_comb
    begin
        priority if (idx_wide == 8'd0) knot_sel = volt_floor_reg;
        else if (idx_wide >= 8'(KNOTS - 1)) knot_sel = knot_top_reg;
        else if (idx_wide == 8'd1) knot_sel = knot_20_reg;
        else if (idx_wide == 8'd2) knot_sel = knot_40_reg;
        else if (idx_wide == 8'd3) knot_sel = knot_60_reg;
        else if (idx_wide == 8'd4) knot_sel = knot_80_reg;
        else knot_sel = knot_top_reg;
    end

    // Segment search step and the divider operands for the found segment.
    always_comb
    begin
        search_more = (idx_wide < 8'(KNOTS - 1)) && (volt_reg >= knot_sel);
        den_sel     = (knot_sel > lo_reg) ? (knot_sel - lo_reg) : VW'(1);
        off_sel     = (volt_reg > lo_reg) ? (volt_reg - lo_reg) : '0;
        num_sel     = NW'(off_sel) * NW'(SEG_PCT);
    end

    bpt_div #(
        .NW(NW),
        .QW(QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (num_sel),
        .den   (den_sel),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Slew counter update for one tick.
    always_comb
    begin
        p_snap     = (synced_reg && !force_reg) ? shown_reg : a_reg;
        a8         = {1'b0, a_reg};
        p8         = {1'b0, p_snap};
        latch_live = load_latch_reg && !chg_reg;
        latch_next = latch_live;
        slew_base  = {slew_reg[15], slew_reg};
        slew_sum   = slew_base;
        priority if ((a8 + bpt_pkg::GAP_CLEAR) < p8)
        begin
            slew_sum = '0;
        end
        else if ((a8 + bpt_pkg::GAP_SMALL) < p8)
        begin
            priority if ((a8 + bpt_pkg::GAP_BIG) < p8) slew_sum = slew_base - 17'sd5;
            else if ((a8 + bpt_pkg::GAP_MID) < p8) slew_sum = slew_base - 17'sd2;
            else slew_sum = slew_base - 17'sd1;
            // A pending load event turns the slow fall into an immediate step.
            if (latch_live)
            begin
                slew_sum   = '0;
                latch_next = 1'b0;
            end
        end
        else if (a8 > (p8 + bpt_pkg::GAP_BIG))
        begin
            slew_sum = slew_base + 17'sd10;
        end
        else if (a8 > (p8 + bpt_pkg::GAP_MID))
        begin
            slew_sum = slew_base + 17'sd2;
        end
        else if (a8 > p8)
        begin
            slew_sum = slew_base + 17'sd1;
        end
        else if (a_reg != '0)
        begin
            slew_sum = {bpt_pkg::SLEW_MID[15], bpt_pkg::SLEW_MID};
        end
        slew_sat = (slew_sum > bpt_pkg::SLEW_MAX) ? 16'sh7FFF : slew_sum[15:0];
    end

    // Percent step when the counter runs out or, while charging, reaches the step level; and resync check.
    always_comb
    begin
        slew_next = slew_reg;
        p_fin     = p_reg;
        if (slew_reg <= 16'sd0)
        begin
            slew_next = bpt_pkg::SLEW_MID;
            if (p_reg != '0)
            begin
                p_fin = p_reg - 1'b1;
            end
        end
        else if ((slew_reg >= bpt_pkg::SLEW_STEP) && chg_reg)
        begin
            slew_next = bpt_pkg::SLEW_MID;
            if (p_reg < bpt_pkg::PCT_FULL)
            begin
                p_fin = p_reg + 1'b1;
            end
        end
        synced_next = !({1'b0, p_fin} > (a8 + bpt_pkg::GAP_RESYNC));
    end

    // Full-charge path.
    always_comb
    begin
        pf        = shown_reg;
        cdf       = cd_reg;
        ramp_next = ramp_reg;
        if (chg_reg)
        begin
            if ((shown_reg < bpt_pkg::PCT_FULL) || (cd_reg != '0))
            begin
                if (shown_reg < bpt_pkg::PCT_JUMP_BELOW)
                begin
                    pf  = bpt_pkg::PCT_FULL;
                    cdf = '0;
                end
                else if (ramp_reg < bpt_pkg::RAMP_TICKS)
                begin
                    ramp_next = ramp_reg + 1'b1;
                end
                else
                begin
                    ramp_next = '0;
                    if (shown_reg < bpt_pkg::PCT_FULL)
                    begin
                        pf = shown_reg + 1'b1;
                    end
                    if (cd_reg != '0)
                    begin
                        cdf = cd_reg - 1'b1;
                    end
                end
            end
        end
        else if (prev_reg > {1'b0, shown_reg})
        begin
            pf  = bpt_pkg::PCT_FULL;
            cdf = '0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bpt_pkg::ST_PREP;
                end
            end
            bpt_pkg::ST_PREP:
            begin
                priority if (full_reg) state_next = bpt_pkg::ST_FULL;
                else if (volt_reg < volt_floor_reg) state_next = bpt_pkg::ST_TRACK;
                else if (volt_reg >= knot_top_reg) state_next = bpt_pkg::ST_TRACK;
                else state_next = bpt_pkg::ST_SEARCH;
            end
            bpt_pkg::ST_SEARCH:
            begin
                if (!search_more)
                begin
                    state_next = bpt_pkg::ST_DIVIDE;
                end
            end
            bpt_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = bpt_pkg::ST_TRACK;
                end
            end
            bpt_pkg::ST_TRACK:  state_next = bpt_pkg::ST_SETTLE;
            bpt_pkg::ST_SETTLE: state_next = bpt_pkg::ST_DONE;
            bpt_pkg::ST_FULL:   state_next = bpt_pkg::ST_DONE;
            bpt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = bpt_pkg::ST_IDLE;
                end
            end
            default: state_next = bpt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer strobes.
    always_comb
    begin
        ctl.in_ready  = (state_reg == bpt_pkg::ST_IDLE);
        ctl.div_start = (state_reg == bpt_pkg::ST_SEARCH) && !search_more;
        ctl.out_load  = (state_reg == bpt_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    end

    // Control and tracker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bpt_pkg::ST_IDLE;
            volt_floor_reg <= bpt_pkg::RST_VOLT_FLOOR;
            knot_20_reg    <= bpt_pkg::RST_KNOT_20;
            knot_40_reg    <= bpt_pkg::RST_KNOT_40;
            knot_60_reg    <= bpt_pkg::RST_KNOT_60;
            knot_80_reg    <= bpt_pkg::RST_KNOT_80;
            knot_top_reg   <= bpt_pkg::RST_KNOT_TOP;
            drop_comp_reg  <= bpt_pkg::RST_DROP_COMP;
            shown_reg      <= '0;
            slew_reg       <= bpt_pkg::SLEW_MID;
            ramp_reg       <= bpt_pkg::RST_RAMP_COUNT;
            prev_reg       <= 8'hFF;
            synced_reg     <= 1'b0;
            load_latch_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bpt_pkg::CFG_VOLT_FLOOR: volt_floor_reg <= cfg_data;
                    bpt_pkg::CFG_KNOT_20:    knot_20_reg    <= cfg_data;
                    bpt_pkg::CFG_KNOT_40:    knot_40_reg    <= cfg_data;
                    bpt_pkg::CFG_KNOT_60:    knot_60_reg    <= cfg_data;
                    bpt_pkg::CFG_KNOT_80:    knot_80_reg    <= cfg_data;
                    bpt_pkg::CFG_KNOT_TOP:   knot_top_reg   <= cfg_data;
                    bpt_pkg::CFG_DROP_COMP:  drop_comp_reg  <= cfg_data[bpt_pkg::DW-1:0];
                    default: ;
                endcase
            end

            // Load events are held until a falling gap uses them or a charging tick clears them.
            if (ctl.in_ready && in_valid && load_event)
            begin
                load_latch_reg <= 1'b1;
            end

            // Below the empty knot the counter starts from zero.
            if ((state_reg == bpt_pkg::ST_PREP) && !full_reg && (volt_reg < volt_floor_reg))
            begin
                slew_reg <= '0;
            end

            if (state_reg == bpt_pkg::ST_TRACK)
            begin
                slew_reg       <= slew_sat;
                load_latch_reg <= latch_next;
            end

            if (state_reg == bpt_pkg::ST_SETTLE)
            begin
                slew_reg   <= slew_next;
                shown_reg  <= p_fin;
                prev_reg   <= {1'b0, p_fin};
                synced_reg <= synced_next;
            end

            if (state_reg == bpt_pkg::ST_FULL)
            begin
                shown_reg  <= pf;
                prev_reg   <= {1'b0, pf};
                ramp_reg   <= ramp_next;
                synced_reg <= 1'b1;
            end

            // Result beat handshake.
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-item datapath and output payload.
    always_ff @(posedge clk)
    begin
        if (ctl.in_ready && in_valid)
        begin
            volt_reg  <= volt_comp;
            chg_reg   <= charging;
            full_reg  <= full_flag;
            force_reg <= force_resync;
            cd_reg    <= countdown_in;
        end

        if (state_reg == bpt_pkg::ST_PREP)
        begin
            idx_reg  <= IW'(1);
            base_reg <= '0;
            lo_reg   <= volt_floor_reg;
            if (volt_reg < volt_floor_reg)
            begin
                a_reg <= '0;
            end
            else
            begin
                a_reg <= chg_reg ? bpt_pkg::PCT_CHG_TOP : bpt_pkg::PCT_FULL;
            end
        end

        // One knot per cycle while the voltage is at or above it.
        if ((state_reg == bpt_pkg::ST_SEARCH) && search_more)
        begin
            lo_reg   <= knot_sel;
            idx_reg  <= idx_reg + 1'b1;
            base_reg <= base_reg + PW'(SEG_PCT);
        end

        if ((state_reg == bpt_pkg::ST_DIVIDE) && div_done)
        begin
            a_reg <= base_reg + PW'(div_quo);
        end

        if (state_reg == bpt_pkg::ST_TRACK)
        begin
            p_reg <= p_snap;
        end

        if (state_reg == bpt_pkg::ST_FULL)
        begin
            cd_reg <= cdf;
        end

        if (ctl.out_load)
        begin
            percent_reg <= shown_reg;
            grade_reg   <= bpt_pkg::grade_of(shown_reg);
            cd_out_reg  <= cd_reg;
        end
    end

    assign in_ready      = ctl.in_ready;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign percent       = percent_reg;
    assign bar_grade     = grade_reg;
    assign countdown_out = cd_out_reg;

endmodule

/* rtl/bpt_div.sv */
// Bit-serial restoring divider for the knot interpolation.
// Produces one quotient bit per cycle; uses bpt_pkg for the divisor width.
module bpt_div #(
    parameter int NW = 15,
    parameter int QW = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NW-1:0]          num,
    input  logic [bpt_pkg::VW-1:0] den,
    output logic                   done,
    output logic [QW-1:0]          quo
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsh_reg;
    logic [QW-1:0] quo_reg;
    logic          fits;
    logic [NW-1:0] rem_next;

    // Trial subtraction of the shifted divisor.
    always_comb
    begin
        fits     = (rem_reg >= dsh_reg);
        rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Remainder, divisor and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= NW'(den) << (QW - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* tb/sv/battery_percent_tracker_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for battery_percent_tracker: random and directed ticks,
// a scoreboard class that predicts each result beat, and random stalls on both sides.
// Depends on bpt_pkg and the battery_percent_tracker RTL only.
module battery_percent_tracker_tb;

    import bpt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int KNOTS          = 6;
    localparam int SEG_PCT        = 100 / (KNOTS - 1);
    localparam int MAX_IDLE       = 17;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SOAK_TICKS     = 3400;
    localparam int MAX_REPORTS    = 40;

    // One input beat: a tick of the tracker.
    typedef struct packed {
        logic [VW-1:0]  volt;
        logic           chg;
        logic           full;
        logic           load;
        logic           snap;
        logic [CDW-1:0] cd;
    } tick_t;

    // One result beat.
    typedef struct packed {
        logic [PW-1:0]  pct;
        logic [GW-1:0]  bars;
        logic [CDW-1:0] cd;
    } soc_result_t;

    // Scoreboard: keeps its own copy of the registers and the tracker state,
    // predicts the result of every accepted tick and checks result beats in order.
    class soc_scoreboard;
        int unsigned regs [8];
        int          shown;
        int          slew;
        int          ramp_cnt;
        int          prev;
        bit          synced;
        bit          load_latch;
        soc_result_t expected_q [$];
        int          errors;
        int          checked;

        function new();
            regs[CFG_VOLT_FLOOR] = RST_VOLT_FLOOR;
            regs[CFG_KNOT_20]    = RST_KNOT_20;
            regs[CFG_KNOT_40]    = RST_KNOT_40;
            regs[CFG_KNOT_60]    = RST_KNOT_60;
            regs[CFG_KNOT_80]    = RST_KNOT_80;
            regs[CFG_KNOT_TOP]   = RST_KNOT_TOP;
            regs[CFG_DROP_COMP]  = RST_DROP_COMP;
            shown      = 0;
            slew       = 100;
            ramp_cnt   = 20;
            prev       = 255;
            synced     = 1'b0;
            load_latch = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void report(string msg);
            if (errors < MAX_REPORTS)
                $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function void set_reg(logic [CIW-1:0] idx, logic [VW-1:0] data);
            if (idx == CFG_DROP_COMP)
                regs[idx] = data[DW-1:0];
            else if (idx <= CFG_KNOT_TOP)
                regs[idx] = data;
        endfunction

        // Knot voltage at a table position; positions past knot_80 read as the top.
        function int unsigned knot_at(int i);
            if (i <= 0)
                return regs[CFG_VOLT_FLOOR];
            if (i >= KNOTS - 1)
                return regs[CFG_KNOT_TOP];
            case (i)
                1: return regs[CFG_KNOT_20];
                2: return regs[CFG_KNOT_40];
                3: return regs[CFG_KNOT_60];
                4: return regs[CFG_KNOT_80];
                default: return regs[CFG_KNOT_TOP];
            endcase
        endfunction

        function logic [GW-1:0] bars_for(int pct);
            if (pct >= 81) return 3'd5;
            if (pct >= 61) return 3'd4;
            if (pct >= 41) return 3'd3;
            if (pct >= 21) return 3'd2;
            if (pct > 0) return 3'd1;
            return 3'd0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted tick and queue it.
        function void note_tick(tick_t t);
            int unsigned v;
            int unsigned lo;
            int unsigned hi;
            int unsigned den;
            int unsigned off;
            int unsigned cdv;
            int          p;
            int          a;
            int          seg;
            bit          hold;
            soc_result_t r;

            v   = t.volt;
            cdv = t.cd;
            p   = shown;
            if (t.load)
                load_latch = 1'b1;

            // Charge-current compensation, saturating at zero.
            if (v > knot_at(0) && t.chg)
                v = (v > regs[CFG_DROP_COMP]) ? v - regs[CFG_DROP_COMP] : 0;

            if (t.full) begin
                // Charge-full handling: jump or slow ramp toward 100.
                if (t.chg) begin
                    if (p < 100 || cdv != 0) begin
                        if (p < 80) begin
                            p   = 100;
                            cdv = 0;
                        end
                        else if (ramp_cnt < 40) begin
                            ramp_cnt++;
                        end
                        else begin
                            ramp_cnt = 0;
                            if (p < 100) p++;
                            if (cdv != 0) cdv--;
                        end
                    end
                end
                else if (prev > p) begin
                    p   = 100;
                    cdv = 0;
                end
                synced = 1'b1;
            end
            else begin
                hold = synced && !t.snap;

                // Piecewise-linear lookup of the raw percent.
                if (v < knot_at(0)) begin
                    a    = 0;
                    slew = 0;
                end
                else if (v >= knot_at(KNOTS - 1)) begin
                    a = t.chg ? 99 : 100;
                end
                else begin
                    seg = 1;
                    while (seg < KNOTS - 1 && v >= knot_at(seg))
                        seg++;
                    lo  = knot_at(seg - 1);
                    hi  = knot_at(seg);
                    den = (hi > lo) ? hi - lo : 1;
                    off = (v > lo) ? v - lo : 0;
                    a   = int'(off * SEG_PCT / den) + (seg - 1) * SEG_PCT;
                end

                if (t.chg)
                    load_latch = 1'b0;
                if (!hold)
                    p = a;

                // Leaky slew counter.
                if (a + 15 < p) begin
                    slew = 0;
                end
                else if (a + 3 < p) begin
                    slew -= (a + 10 < p) ? 5 : ((a + 5 < p) ? 2 : 1);
                    if (load_latch && !t.chg) begin
                        slew       = 0;
                        load_latch = 1'b0;
                    end
                end
                else if (a > p + 10) slew += 10;
                else if (a > p + 5) slew += 2;
                else if (a > p) slew += 1;
                else if (a != 0) slew = 100;
                if (slew > 32767)
                    slew = 32767;

                if (slew <= 0) begin
                    slew = 100;
                    if (p > 0) p--;
                end
                else if (slew >= 200 && t.chg) begin
                    slew = 100;
                    if (p < 100) p++;
                end

                synced = !(p > a + 30);
            end

            shown  = p & 'h7F;
            prev   = shown;
            r.pct  = PW'(shown);
            r.bars = bars_for(shown);
            r.cd   = CDW'(cdv);
            expected_q.push_back(r);
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_result(logic [PW-1:0] got_pct, logic [GW-1:0] got_bars,
                                   logic [CDW-1:0] got_cd);
            soc_result_t exp_r;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %0d arrived with nothing expected", checked));
                checked++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got_pct !== exp_r.pct)
                report($sformatf("beat %0d percent got %0d expected %0d",
                                 checked, got_pct, exp_r.pct));
            if (got_bars !== exp_r.bars)
                report($sformatf("beat %0d bar_grade got %0d expected %0d",
                                 checked, got_bars, exp_r.bars));
            if (got_cd !== exp_r.cd)
                report($sformatf("beat %0d countdown_out got %0d expected %0d",
                                 checked, got_cd, exp_r.cd));
            checked++;
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [VW-1:0]  cell_volt = '0;
    logic           charging = 1'b0;
    logic           full_flag = 1'b0;
    logic           load_event = 1'b0;
    logic           force_resync = 1'b0;
    logic [CDW-1:0] countdown_in = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [PW-1:0]  percent;
    logic [GW-1:0]  bar_grade;
    logic [CDW-1:0] countdown_out;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [CIW-1:0] cfg_index = '0;
    logic [VW-1:0]  cfg_data = '0;

    soc_scoreboard sb;

    int quiet_cycles = 0;
    int ticks_sent = 0;
    int cfg_writes = 0;
    int table_settings = 0;
    int holds_done = 0;
    bit no_idle = 1'b0;
    bit hold_off_req = 1'b0;
    int drift_v = 380;
    bit drift_chg = 1'b0;
    int band_lo = 314;
    int band_hi = 431;

    battery_percent_tracker #(
        .KNOTS(KNOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cell_volt    (cell_volt),
        .charging     (charging),
        .full_flag    (full_flag),
        .load_event   (load_event),
        .force_resync (force_resync),
        .countdown_in (countdown_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .percent      (percent),
        .bar_grade    (bar_grade),
        .countdown_out(countdown_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("battery_percent_tracker verification failed");
            $finish;
        end
    end

    // Idle cycles before a beat; zero during stretches without idling.
    function automatic int draw_idle();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic tick_t make_tick(logic [VW-1:0] volt, bit chg, bit full, bit load,
                                        bit snap, logic [CDW-1:0] cd);
        tick_t t;
        t.volt = volt;
        t.chg  = chg;
        t.full = full;
        t.load = load;
        t.snap = snap;
        t.cd   = cd;
        return t;
    endfunction

    // Random tick: mostly a slowly drifting voltage, with jumps and fully random beats.
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        int    step;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 24) == 0)
            drift_chg = ~drift_chg;
        if (pick < 15)
        begin
            return make_tick(VW'($urandom_range(0, 1023)), ($urandom_range(0, 1) == 1),
                             ($urandom_range(0, 1) == 1), ($urandom_range(0, 1) == 1),
                             ($urandom_range(0, 1) == 1), CDW'($urandom_range(0, 127)));
        end
        if (pick < 30)
        begin
            drift_v = $urandom_range(band_lo, band_hi);
        end
        else
        begin
            step    = $urandom_range(0, 8);
            drift_v = drift_v + step - 4;
            if (drift_v < 0) drift_v = 0;
            if (drift_v > 1023) drift_v = 1023;
        end
        t.volt = VW'(drift_v);
        t.chg  = drift_chg;
        t.full = ($urandom_range(0, 39) == 0);
        t.load = ($urandom_range(0, 5) == 0);
        t.snap = ($urandom_range(0, 29) == 0);
        t.cd   = ($urandom_range(0, 9) == 0) ? CDW'($urandom_range(121, 127))
                                              : CDW'($urandom_range(0, 120));
        return t;
    endfunction

    // Random voltages cover the knot span of the current table plus a margin.
    function automatic void set_band();
        int unsigned lo_v;
        int unsigned hi_v;
        int          i;
        lo_v = 1023;
        hi_v = 0;
        for (i = 0; i < KNOTS; i++)
        begin
            if (sb.knot_at(i) < lo_v) lo_v = sb.knot_at(i);
            if (sb.knot_at(i) > hi_v) hi_v = sb.knot_at(i);
        end
        band_lo = (lo_v > 16) ? lo_v - 16 : 0;
        band_hi = (hi_v + 16 > 1023) ? 1023 : hi_v + 16;
        drift_v = band_lo + (band_hi - band_lo) / 2;
    endfunction

    // Offer one tick after a random gap and hold it until the beat is taken.
    task automatic send_tick(input tick_t t);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_volt    <= t.volt;
        charging     <= t.chg;
        full_flag    <= t.full;
        load_event   <= t.load;
        force_resync <= t.snap;
        countdown_in <= t.cd;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_tick(t);
        ticks_sent++;
    endtask

    // Stop offering ticks until every predicted result beat has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Drain, then give the block time to fall idle.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CIW-1:0] idx, input logic [VW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_writes++;
    endtask

    // Write the whole knot table and the compensation; only called while idle.
    task automatic program_table(input logic [VW-1:0] floor_v, input logic [VW-1:0] k20,
                                 input logic [VW-1:0] k40, input logic [VW-1:0] k60,
                                 input logic [VW-1:0] k80, input logic [VW-1:0] top,
                                 input logic [VW-1:0] drop);
        settle();
        put_reg(CFG_VOLT_FLOOR, floor_v);
        put_reg(CFG_KNOT_20, k20);
        put_reg(CFG_KNOT_40, k40);
        put_reg(CFG_KNOT_60, k60);
        put_reg(CFG_KNOT_80, k80);
        put_reg(CFG_KNOT_TOP, top);
        put_reg(CFG_DROP_COMP, drop);
        cfg_valid <= 1'b0;
        set_band();
        table_settings++;
    endtask

    // Charge-full episode: optional run-up near the top, then full held for a while.
    task automatic charge_episode(output int sent);
        int k;
        int len;
        int cdn;
        len  = $urandom_range(45, 95);
        cdn  = $urandom_range(1, 120);
        sent = 0;
        if ($urandom_range(0, 1) == 1)
        begin
            // Snap high first so the slow ramp is taken instead of the jump.
            for (k = 0; k < 4; k++)
            begin
                send_tick(make_tick(VW'(band_hi), 1'b1, 1'b0, 1'b0, (k == 0), CDW'(cdn)));
                sent++;
            end
        end
        for (k = 0; k < len; k++)
        begin
            if (cdn > 0 && $urandom_range(0, 9) == 0)
                cdn--;
            send_tick(make_tick(VW'($urandom_range(band_lo, band_hi)),
                                ($urandom_range(0, 19) != 0), 1'b1,
                                ($urandom_range(0, 7) == 0), ($urandom_range(0, 19) == 0),
                                CDW'(cdn)));
            sent++;
        end
    endtask

    // Mixed random traffic with stretches without idling and occasional drains.
    task automatic run_mix(input int n);
        int sent_n;
        int got;
        int stretch;
        sent_n  = 0;
        stretch = 0;
        while (sent_n < n)
        begin
            if (stretch == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(20, 60);
            end
            stretch--;
            if ($urandom_range(0, 149) == 0)
            begin
                charge_episode(got);
                sent_n += got;
            end
            else
            begin
                send_tick(random_tick());
                sent_n++;
            end
            if ($urandom_range(0, 149) == 0)
                drain_results();
        end
        no_idle = 1'b0;
    endtask

    // Hold the voltage above the top knot without charging so the slew
    // counter climbs into saturation, then charge to expose any wrap.
    task automatic slew_soak();
        int k;
        send_tick(make_tick(VW'(sb.knot_at(1)), 1'b0, 1'b0, 1'b0, 1'b1, CDW'(0)));
        for (k = 0; k < SOAK_TICKS; k++)
            send_tick(make_tick(VW'($urandom_range(sb.knot_at(KNOTS - 1), 1023)), 1'b0, 1'b0,
                                ($urandom_range(0, 1) == 1), 1'b0,
                                CDW'($urandom_range(0, 127))));
        for (k = 0; k < 30; k++)
            send_tick(make_tick(VW'($urandom_range(sb.knot_at(KNOTS - 1), 1023)), 1'b1, 1'b0,
                                1'b0, 1'b0, CDW'($urandom_range(0, 120))));
    endtask

    // Result side: random stall before each beat, one long hold-off on request.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                stall        = HOLD_CYCLES;
                hold_off_req = 1'b0;
                holds_done++;
            end
            else
            begin
                stall = draw_idle();
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(percent, bar_grade, countdown_out);
        end
    end

    // Main sequence.
    initial
    begin : stimulus
        int k;
        int unsigned v;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks on the reset table. The first one is full while not
        // charging, the only tick where the previous percent exceeds the current.
        send_tick(make_tick(10'd400, 1'b0, 1'b1, 1'b0, 1'b0, 7'd77));
        send_tick(make_tick(10'd0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0));
        send_tick(make_tick(10'd1023, 1'b0, 1'b0, 1'b0, 1'b1, 7'd120));
        send_tick(make_tick(10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1));
        send_tick(make_tick(10'd330, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5));
        send_tick(make_tick(10'd365, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5));
        send_tick(make_tick(10'd371, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5));
        send_tick(make_tick(10'd383, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5));
        send_tick(make_tick(10'd397, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5));
        send_tick(make_tick(10'd415, 1'b0, 1'b0, 1'b0, 1'b1, 7'd5));
        // Load latched at 80 percent, then a fall of about ten points consumes it.
        send_tick(make_tick(10'd397, 1'b0, 1'b0, 1'b1, 1'b1, 7'd0));
        send_tick(make_tick(10'd390, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0));
        // Full while charging: jump from 40, then ramp, then nothing left to do.
        send_tick(make_tick(10'd371, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0));
        send_tick(make_tick(10'd371, 1'b1, 1'b1, 1'b0, 1'b0, 7'd90));
        send_tick(make_tick(10'd371, 1'b1, 1'b1, 1'b0, 1'b0, 7'd90));
        send_tick(make_tick(10'd371, 1'b1, 1'b1, 1'b0, 1'b0, 7'd0));
        // Countdown above its range passes through; a big fall clears the counter.
        send_tick(make_tick(10'd350, 1'b0, 1'b0, 1'b0, 1'b0, 7'd127));
        send_tick(make_tick(10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, 7'd121));

        // Reset table, random traffic with one long output hold-off.
        run_mix(60);
        hold_off_req = 1'b1;
        no_idle      = 1'b1;
        for (k = 0; k < 12; k++)
            send_tick(random_tick());
        no_idle = 1'b0;
        run_mix(180);

        // Wide table with maximum compensation: compensation underflow.
        program_table(10'd0, 10'd200, 10'd400, 10'd600, 10'd800, 10'd1023, 10'd63);
        send_tick(make_tick(10'd10, 1'b1, 1'b0, 1'b0, 1'b1, 7'd3));
        send_tick(make_tick(10'd63, 1'b1, 1'b0, 1'b0, 1'b0, 7'd3));
        send_tick(make_tick(10'd64, 1'b1, 1'b0, 1'b0, 1'b1, 7'd3));
        run_mix(150);

        // All registers at the low extreme, then at the high extreme.
        program_table(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        run_mix(80);
        program_table(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        run_mix(80);

        // Unordered random tables.
        for (k = 0; k < 3; k++)
        begin
            program_table(VW'($urandom_range(0, 1023)), VW'($urandom_range(0, 1023)),
                          VW'($urandom_range(0, 1023)), VW'($urandom_range(0, 1023)),
                          VW'($urandom_range(0, 1023)), VW'($urandom_range(0, 1023)),
                          VW'($urandom_range(0, 1023)));
            run_mix(80);
        end

        // Ordered random table with random knot spacing.
        v = $urandom_range(250, 350);
        program_table(VW'(v), VW'(v + 5), VW'(v + 5 + $urandom_range(1, 40)),
                      VW'(v + 50 + $urandom_range(1, 40)), VW'(v + 95 + $urandom_range(1, 40)),
                      VW'(v + 140 + $urandom_range(1, 40)), VW'($urandom_range(0, 63)));
        run_mix(150);

        // Back to the reset table for the slew counter soak.
        program_table(RST_VOLT_FLOOR, RST_KNOT_20, RST_KNOT_40, RST_KNOT_60, RST_KNOT_80,
                      RST_KNOT_TOP, VW'($urandom_range(0, 20)));
        slew_soak();
        run_mix(100);

        settle();
        $display("Run covered %0d ticks over %0d register settings (%0d writes); %0d results checked.",
                 ticks_sent, table_settings, cfg_writes, sb.checked);
        $display("It included %0d output hold-off(s) of %0d cycles and a %0d-tick slew soak.",
                 holds_done, HOLD_CYCLES, SOAK_TICKS);
        if (sb.errors == 0)
            $display("battery_percent_tracker verification clean");
        else
            $display("battery_percent_tracker verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/bpt_pkg.sv
rtl/bpt_div.sv
rtl/battery_percent_tracker.sv
tb/sv/battery_percent_tracker_tb.sv
